/* rtl/kts_pkg.sv */
// Shared types and constants for the keyframe track sampler.
package kts_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_MODE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOPING   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAYING   = 3'd5;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   localparam logic [WORD_W-1:0] SPEED_RESET = 32'h0001_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_WRAP,
      ST_FIRST,
      ST_LAST,
      ST_SEARCH,
      ST_SEARCH_WAIT,
      ST_FETCH,
      ST_ALPHA,
      ST_BLEND,
      ST_DONE
   } state_type;

   // request to the shared serial divider
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;   // non-negative
      logic [31:0] divisor;    // positive
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quotient;
      logic [31:0] remainder;
   } div_rsp_type;

endpackage

/* rtl/kts_divider.sv */
// Restoring divider, one quotient bit per cycle, shared by wrap and alpha.
module kts_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  kts_pkg::div_req_type req,
   output kts_pkg::div_rsp_type rsp
);

   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quo_ff[63]};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.busy      = busy_ff;
   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff[31:0];

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(busy_ff))
      else $error("divider done without busy");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff[31:0] < dvs_ff))
      else $error("divider remainder out of range");

endmodule

/* rtl/keyframe_track_sampler.sv */
// Top level of the keyframe track sampler: key store, sequencer and datapath.
// A load transaction writes one key slot at the edge that accepts it and returns
// nothing, so loads can follow back to back, one per cycle. An advance transaction
// returns one result. When not playing or no keys are in use it skips the
// datapath and returns a zero result. Otherwise a clock at or below the first key
// takes the first key and one at or above the last key takes the last key.
// Between two keys a binary search runs (log2 of MAX_KEYS probes at most, 6 for
// 64 keys). The 64-step serial divider serves the loop wrap and, when the gap is
// positive in linear mode, alpha.
// start is taken only while busy is low; each result is shown for one cycle
// with rsp_valid and the receiver cannot stall it.
module keyframe_track_sampler #(
   parameter int unsigned MAX_KEYS   = 64,
   parameter int unsigned COMPONENTS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [5:0]  req_key_index,
   input  logic signed [31:0] req_key_time,
   input  logic signed [31:0] req_key_x,
   input  logic signed [31:0] req_key_y,
   input  logic signed [31:0] req_key_z,
   input  logic signed [31:0] req_delta,
   output logic        rsp_valid,
   output logic        rsp_sampled,
   output logic signed [31:0] rsp_clock_now,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   input  logic        csr_write,
   input  logic [kts_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kts_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int unsigned IDX_W = $clog2(MAX_KEYS);
   localparam int unsigned CNT_W = $clog2(MAX_KEYS + 1);
   localparam int unsigned NC    = (COMPONENTS > 3) ? 3 : COMPONENTS;
   localparam int unsigned VAL_W = 32 * COMPONENTS;

   // configuration
   logic [6:0]  key_count_ff;
   logic        step_mode_ff, looping_ff, playing_ff;
   logic signed [31:0] speed_ff;
   logic [30:0] duration_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
         step_mode_ff <= 1'b0;
         speed_ff     <= kts_pkg::SPEED_RESET;
         duration_ff  <= '0;
         looping_ff   <= 1'b0;
         playing_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            kts_pkg::CSR_KEY_COUNT: key_count_ff <= csr_data[6:0];
            kts_pkg::CSR_STEP_MODE: step_mode_ff <= csr_data[0];
            kts_pkg::CSR_SPEED:     speed_ff     <= csr_data;
            kts_pkg::CSR_DURATION:  duration_ff  <= csr_data[30:0];
            kts_pkg::CSR_LOOPING:   looping_ff   <= csr_data[0];
            kts_pkg::CSR_PLAYING:   playing_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // key stores: one write, one registered read
   logic [31:0]      time_mem [MAX_KEYS];
   logic [VAL_W-1:0] val_mem  [MAX_KEYS];
   logic [IDX_W-1:0] rd_addr;
   logic [31:0]      rd_time_ff;
   logic [VAL_W-1:0] rd_val_ff;
   logic             wr_en;
   logic [VAL_W-1:0] wr_val;
   logic [95:0]      req_vals;

   assign req_vals = {req_key_z, req_key_y, req_key_x};
   always_comb begin
      wr_val = '0;
      for (int c = 0; c < NC; c++) begin
         wr_val[32*c +: 32] = req_vals[32*c +: 32];
      end
   end
   assign wr_en = start && !busy && (req_op == kts_pkg::OP_LOAD)
                  && ({26'd0, req_key_index} < 32'(MAX_KEYS));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[IDX_W'(req_key_index)] <= req_key_time;
         val_mem[IDX_W'(req_key_index)]  <= wr_val;
      end
      rd_time_ff <= time_mem[rd_addr];
      rd_val_ff  <= val_mem[rd_addr];
   end

   // sequencer state
   kts_pkg::state_type state_ff, state_in;
   kts_pkg::div_req_type div_req;
   kts_pkg::div_rsp_type div_rsp;

   logic signed [31:0] delta_ff, delta_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] clk_ff, clk_in;       // play clock
   logic signed [31:0] t_ff, t_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [IDX_W-1:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic signed [31:0] t0_ff, t0_in, t1_ff, t1_in;
   logic [VAL_W-1:0]   v0_ff, v0_in, v1_ff, v1_in;
   logic [16:0]        alpha_ff, alpha_in;
   logic [1:0]         comp_ff, comp_in;
   logic [95:0]        res_ff, res_in;
   logic               sampled_ff, sampled_in;
   logic               valid_ff, valid_in;
   logic               neg_ff, neg_in;
   logic               fetch_hi_ff, fetch_hi_in;

   logic signed [48:0] sum;
   logic signed [32:0] tsat_src;
   logic signed [31:0] tsat;
   logic signed [32:0] gap;
   logic [IDX_W:0]     mid_w;
   logic [IDX_W-1:0]   mid;
   logic signed [32:0] va, vb, dv;
   logic signed [50:0] bprod;
   logic signed [34:0] bsum;
   logic [31:0]        dur32;
   logic [CNT_W-1:0]   kc_sat;
   logic [32:0]        tneg;
   logic [31:0]        wr_rem;

   assign dur32  = {1'b0, duration_ff};
   assign kc_sat = (32'(key_count_ff) > 32'(MAX_KEYS)) ? CNT_W'(MAX_KEYS)
                                                       : CNT_W'(key_count_ff);
   assign mid_w = ({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1;
   assign mid   = mid_w[IDX_W-1:0];

   // floor(prod/65536) is an arithmetic shift
   assign sum = 49'(clk_ff) + 49'(prod_ff >>> 16);
   always_comb begin
      if (sum > 49'sd2147483647)        tsat = 32'h7FFF_FFFF;
      else if (sum < -49'sd2147483648)  tsat = 32'h8000_0000;
      else                              tsat = sum[31:0];
   end
   assign tsat_src = 33'(tsat);
   assign tneg   = 33'(-tsat_src);
   assign wr_rem = div_rsp.remainder;
   assign gap    = 33'(t1_ff) - 33'(t0_ff);

   always_comb begin
      va = '0;
      vb = '0;
      for (int c = 0; c < NC; c++) begin
         if (comp_ff == 2'(c)) begin
            va = 33'($signed(v0_ff[32*c +: 32]));
            vb = 33'($signed(v1_ff[32*c +: 32]));
         end
      end
   end
   assign dv    = vb - va;
   assign bprod = 51'(dv) * $signed({34'd0, alpha_ff});
   assign bsum  = 35'(va) + 35'(bprod >>> 16);

   always_comb begin
      state_in    = state_ff;
      delta_in    = delta_ff;
      prod_in     = prod_ff;
      clk_in      = clk_ff;
      t_in        = t_ff;
      n_in        = n_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      t0_in       = t0_ff;
      t1_in       = t1_ff;
      v0_in       = v0_ff;
      v1_in       = v1_ff;
      alpha_in    = alpha_ff;
      comp_in     = comp_ff;
      res_in      = res_ff;
      sampled_in  = sampled_ff;
      valid_in    = 1'b0;
      neg_in      = neg_ff;
      fetch_hi_in = fetch_hi_ff;
      rd_addr     = '0;
      div_req     = '0;
      unique case (state_ff)
         kts_pkg::ST_IDLE: begin
            if (start && !busy && req_op == kts_pkg::OP_ADVANCE) begin
               delta_in = req_delta;
               n_in     = kc_sat;
               if (!playing_ff || kc_sat == '0) begin
                  sampled_in = 1'b0;
                  res_in     = '0;
                  state_in   = kts_pkg::ST_DONE;
               end else begin
                  state_in = kts_pkg::ST_MUL;
               end
            end
         end
         kts_pkg::ST_MUL: begin
            prod_in  = 64'(delta_ff) * 64'(speed_ff);
            state_in = kts_pkg::ST_ADD;
         end
         kts_pkg::ST_ADD: begin
            t_in     = tsat;
            state_in = kts_pkg::ST_FIRST;
            if (duration_ff != '0) begin
               if (looping_ff) begin
                  neg_in           = tsat[31];
                  div_req.start    = 1'b1;
                  div_req.dividend = tsat[31] ? 64'(tneg) : 64'(tsat_src[31:0]);
                  div_req.divisor  = dur32;
                  state_in         = kts_pkg::ST_WRAP;
               end else if (tsat < 0) begin
                  t_in = '0;
               end else if (tsat > $signed(dur32)) begin
                  t_in = dur32;
               end
            end
         end
         kts_pkg::ST_WRAP: begin
            if (div_rsp.done) begin
               if (neg_ff && wr_rem != '0) t_in = dur32 - wr_rem;
               else                        t_in = wr_rem;
               state_in = kts_pkg::ST_FIRST;
            end
         end
         kts_pkg::ST_FIRST: begin
            clk_in      = t_ff;
            rd_addr     = '0;
            fetch_hi_in = 1'b0;
            neg_in      = 1'b0;
            state_in    = kts_pkg::ST_LAST;
         end
         kts_pkg::ST_LAST: begin
            // first key arrives; request last key
            rd_addr  = IDX_W'(n_ff - CNT_W'(1));
            t0_in    = rd_time_ff;
            v0_in    = rd_val_ff;
            v1_in    = rd_val_ff;
            alpha_in = '0;
            if (n_ff == CNT_W'(1) || t_ff <= $signed(rd_time_ff)) begin
               state_in = kts_pkg::ST_BLEND;
               comp_in  = '0;
            end else begin
               state_in = kts_pkg::ST_SEARCH;
            end
         end
         kts_pkg::ST_SEARCH: begin
            if (fetch_hi_ff == 1'b0) begin
               // last key arrives
               if (t_ff >= $signed(rd_time_ff)) begin
                  v0_in    = rd_val_ff;
                  v1_in    = rd_val_ff;
                  comp_in  = '0;
                  state_in = kts_pkg::ST_BLEND;
               end else begin
                  lo_in       = '0;
                  hi_in       = IDX_W'(n_ff - CNT_W'(1));
                  fetch_hi_in = 1'b1;
               end
            end else if ({1'b0, lo_ff} + 1'b1 < {1'b0, hi_ff}) begin
               rd_addr  = mid;
               state_in = kts_pkg::ST_SEARCH_WAIT;
            end else begin
               rd_addr  = lo_ff;
               state_in = kts_pkg::ST_FETCH;
            end
         end
         kts_pkg::ST_SEARCH_WAIT: begin
            // probe of mid is back; narrow the bracket
            if ($signed(rd_time_ff) <= t_ff) lo_in = mid;
            else                             hi_in = mid;
            state_in = kts_pkg::ST_SEARCH;
         end
         kts_pkg::ST_FETCH: begin
            // lower key ready, read upper
            rd_addr  = hi_ff;
            t0_in    = rd_time_ff;
            v0_in    = rd_val_ff;
            comp_in  = '1;
            state_in = kts_pkg::ST_ALPHA;
         end
         kts_pkg::ST_ALPHA: begin
            if (comp_ff == '1) begin
               t1_in   = rd_time_ff;
               v1_in   = rd_val_ff;
               comp_in = '0;
            end else if (!div_rsp.busy && !div_rsp.done && !neg_ff) begin
               if (gap > 0 && !step_mode_ff) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {15'd0, 33'(t_ff) - 33'(t0_ff), 16'd0};
                  div_req.divisor  = gap[31:0];
                  neg_in           = 1'b1;
               end else begin
                  alpha_in = '0;
                  state_in = kts_pkg::ST_BLEND;
               end
            end else if (div_rsp.done) begin
               alpha_in = (div_rsp.quotient > 64'd65536) ? 17'h10000
                                                         : div_rsp.quotient[16:0];
               neg_in   = 1'b0;
               state_in = kts_pkg::ST_BLEND;
            end
         end
         kts_pkg::ST_BLEND: begin
            if (step_mode_ff) alpha_in = '0;
            if (comp_ff == 2'(NC)) begin
               sampled_in = 1'b1;
               state_in   = kts_pkg::ST_DONE;
            end else begin
               if (step_mode_ff) begin
                  res_in[32*comp_ff +: 32] = va[31:0];
               end else if (bsum > 35'sd2147483647) begin
                  res_in[32*comp_ff +: 32] = 32'h7FFF_FFFF;
               end else if (bsum < -35'sd2147483648) begin
                  res_in[32*comp_ff +: 32] = 32'h8000_0000;
               end else begin
                  res_in[32*comp_ff +: 32] = bsum[31:0];
               end
               comp_in = comp_ff + 2'd1;
            end
            if (comp_ff == '0) begin
               for (int c = 0; c < 3; c++) if (c >= NC) res_in[32*c +: 32] = '0;
            end
         end
         kts_pkg::ST_DONE: begin
            valid_in = 1'b1;
            state_in = kts_pkg::ST_IDLE;
         end
         default: state_in = kts_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kts_pkg::ST_IDLE;
         valid_ff <= 1'b0;
         clk_ff   <= '0;
         neg_ff   <= 1'b0;
         alpha_ff <= '0;
         comp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         clk_ff   <= clk_in;
         neg_ff   <= neg_in;
         alpha_ff <= alpha_in;
         comp_ff  <= comp_in;
      end
      delta_ff    <= delta_in;
      prod_ff     <= prod_in;
      t_ff        <= t_in;
      n_ff        <= n_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      t0_ff       <= t0_in;
      t1_ff       <= t1_in;
      v0_ff       <= v0_in;
      v1_ff       <= v1_in;
      res_ff      <= res_in;
      sampled_ff  <= sampled_in;
      fetch_hi_ff <= fetch_hi_in;
   end

   kts_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign busy          = (state_ff != kts_pkg::ST_IDLE) || valid_ff;
   assign rsp_valid     = valid_ff;
   assign rsp_sampled   = sampled_ff;
   assign rsp_clock_now = clk_ff;
   assign rsp_out_x     = res_ff[31:0];
   assign rsp_out_y     = res_ff[63:32];
   assign rsp_out_z     = res_ff[95:64];

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result while idle");
   a_valid_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result held longer than one cycle");
   a_done_leads: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == kts_pkg::ST_DONE))
      else $error("result without done state");

endmodule
